>>> sv/ors_pkg.sv
package ors_pkg;

  localparam int KeyW  = 40;
  localparam int LocW  = 31;
  localparam int StW   = 16;
  localparam int TypeW = 8;

  typedef enum logic [1:0] {
    CMD_SAVE   = 2'd0,
    CMD_REWIND = 2'd1,
    CMD_GET    = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic start;
    logic type_first;
  } ors_ctrl_t;

  // Key is packed as from[39:24] to[23:8] type[7:0]
  function automatic logic [KeyW-1:0] rank_of(input logic [KeyW-1:0] key,
                                              input logic type_first);
    logic [KeyW-1:0] r;
    if (type_first) begin
      r = {key[TypeW-1:0], key[KeyW-1:TypeW]};
    end else begin
      r = key;
    end
    return r;
  endfunction

endpackage

>>> sv/ors_rank_cmp.sv
module ors_rank_cmp (
  input  logic [ors_pkg::KeyW-1:0] key_a,
  input  logic [ors_pkg::KeyW-1:0] key_b,
  input  logic                     type_first,
  output logic                     a_less
);
  import ors_pkg::*;

  // rank both keys in the chosen order, then one wide compare
  assign a_less = rank_of(key_a, type_first) < rank_of(key_b, type_first);

endmodule

>>> sv/ors_sorter.sv
module ors_sorter #(
  parameter int MAX_RECORDS = 1024,
  parameter int IW = $clog2(MAX_RECORDS),
  parameter int CW = $clog2(MAX_RECORDS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  ors_pkg::ors_ctrl_t       ctrl,
  input  logic [CW-1:0]            rec_count,
  input  logic                     key_we,
  input  logic [IW-1:0]            key_waddr,
  input  logic [ors_pkg::KeyW-1:0] key_wdata,
  input  logic [IW-1:0]            look_addr,
  output logic [IW-1:0]            look_idx,
  output logic                     sort_done
);
  import ors_pkg::*;

  localparam int LW = CW + 2;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SETUP = 6'b000010,
    S_RUN   = 6'b000100,
    S_ORD   = 6'b001000,
    S_KEY   = 6'b010000,
    S_CMP   = 6'b100000
  } sort_state_t;

  sort_state_t state;
  logic [LW-1:0] width, lo, mid, hi, i, j, k, n;
  logic [LW-1:0] lo_w, lo_2w;
  logic          p, passes, type_first;

  logic [KeyW-1:0] key_mem [MAX_RECORDS];
  logic [IW-1:0]   ord0 [MAX_RECORDS];
  logic [IW-1:0]   ord1 [MAX_RECORDS];

  logic [IW-1:0]   addr_a, addr_b;
  logic [IW-1:0]   rd0a, rd0b, rd1a, rd1b, src_a, src_b;
  logic [IW-1:0]   oi_c, oj_c, oi, oj, look_q;
  logic [KeyW-1:0] ka, kb;
  logic            b_lt_a, take_i;

  assign n = LW'(rec_count);

  // order reads: port a serves the result lookup when idle
  assign addr_a = (state == S_IDLE) ? look_addr : i[IW-1:0];
  assign addr_b = j[IW-1:0];
  assign src_a  = p ? rd1a : rd0a;
  assign src_b  = p ? rd1b : rd0b;
  assign oi_c   = passes ? src_a : i[IW-1:0];
  assign oj_c   = passes ? src_b : j[IW-1:0];
  assign look_idx = passes ? src_a : look_q;

  always_ff @(posedge clk) begin
    rd0a   <= ord0[addr_a];
    rd0b   <= ord0[addr_b];
    rd1a   <= ord1[addr_a];
    rd1b   <= ord1[addr_b];
    look_q <= look_addr;
    if (state == S_CMP) begin
      if (p) begin
        ord0[k[IW-1:0]] <= take_i ? oi : oj;
      end else begin
        ord1[k[IW-1:0]] <= take_i ? oi : oj;
      end
    end
  end

  // key store: written on save, read twice per merge step
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    ka <= key_mem[oi_c];
    kb <= key_mem[oj_c];
    if (state == S_KEY) begin
      oi <= oi_c;
      oj <= oj_c;
    end
  end

  ors_rank_cmp u_cmp (
    .key_a      (kb),
    .key_b      (ka),
    .type_first (type_first),
    .a_less     (b_lt_a)
  );

  // stable merge: left run wins unless right is strictly less
  assign take_i = (j >= hi) || ((i < mid) && !b_lt_a);

  assign lo_w  = lo + width;
  assign lo_2w = lo + (width << 1);

  // bottom-up merge sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      sort_done <= 1'b0;
      p         <= 1'b0;
      passes    <= 1'b0;
    end else begin
      sort_done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (ctrl.start) begin
            type_first <= ctrl.type_first;
            width      <= LW'(1);
            p          <= 1'b0;
            passes     <= 1'b0;
            state      <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (width >= n) begin
            sort_done <= 1'b1;
            state     <= S_IDLE;
          end else begin
            lo    <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (lo >= n) begin
            width  <= width << 1;
            p      <= ~p;
            passes <= 1'b1;
            state  <= S_SETUP;
          end else begin
            mid   <= (lo_w < n) ? lo_w : n;
            j     <= (lo_w < n) ? lo_w : n;
            hi    <= (lo_2w < n) ? lo_2w : n;
            i     <= lo;
            k     <= lo;
            state <= S_ORD;
          end
        end
        S_ORD: state <= S_KEY;
        S_KEY: state <= S_CMP;
        S_CMP: begin
          k <= k + LW'(1);
          if (take_i) begin
            i <= i + LW'(1);
          end else begin
            j <= j + LW'(1);
          end
          if (k + LW'(1) == hi) begin
            lo    <= hi;
            state <= S_RUN;
          end else begin
            state <= S_ORD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> sv/observation_record_sorter.sv
// Save, rewind and ignored codes: accepted while idle, busy stays low.
// Get-next past the end or with nothing saved: done the cycle after the accepting edge.
// Get-next with a record: busy through T_LOOK, T_LOC and T_OUT, done registered in T_OUT,
// so no new word is accepted before the last one is out.
// First get-next with unread records first runs a bottom-up merge sort,
// stepping through S_ORD, S_KEY and S_CMP per merged word on the order memories.
// Synchronous active-high reset clears count, pointer, flags and mode;
// stores are undefined until written. The receiver cannot stall results.
module observation_record_sorter #(
  parameter int MAX_RECORDS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [15:0] from_station,
  input  logic [15:0] to_station,
  input  logic [7:0]  obs_type,
  input  logic [30:0] location,
  input  logic        sort_mode_we,
  input  logic [1:0]  sort_mode_wdata,
  output logic        done,
  output logic [30:0] sorted_location,
  output logic        end_of_list,
  output logic        overflow
);
  import ors_pkg::*;

  localparam int IW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  typedef enum logic [4:0] {
    T_IDLE = 5'b00001,
    T_SORT = 5'b00010,
    T_LOOK = 5'b00100,
    T_LOC  = 5'b01000,
    T_OUT  = 5'b10000
  } top_state_t;

  top_state_t state;
  logic [1:0]      sort_mode;
  logic [CW-1:0]   rec_count, read_ptr;
  logic            sorted_flag, overflow_flag;
  logic            accept, do_save, swap, sort_done;
  logic [KeyW-1:0] key_wdata;
  logic [IW-1:0]   look_idx;
  logic [LocW-1:0] loc_mem [MAX_RECORDS];
  logic [LocW-1:0] loc_rd;
  ors_ctrl_t       ctrl;

  assign busy   = (state != T_IDLE);
  assign accept = start && !busy;

  // orient the station pair
  assign swap = (from_station == '0) ||
                (sort_mode[0] && (to_station != '0) && (to_station < from_station));
  assign key_wdata = swap ? {to_station, from_station, obs_type}
                          : {from_station, to_station, obs_type};
  assign do_save = accept && (cmd_t'(cmd) == CMD_SAVE) && !sorted_flag &&
                   (rec_count != CW'(MAX_RECORDS));

  assign ctrl.start      = accept && (cmd_t'(cmd) == CMD_GET) &&
                           (read_ptr < rec_count) && !sorted_flag;
  assign ctrl.type_first = sort_mode[1];

  ors_sorter #(.MAX_RECORDS(MAX_RECORDS)) u_sorter (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .rec_count (rec_count),
    .key_we    (do_save),
    .key_waddr (rec_count[IW-1:0]),
    .key_wdata (key_wdata),
    .look_addr (read_ptr[IW-1:0]),
    .look_idx  (look_idx),
    .sort_done (sort_done)
  );

  // location store
  always_ff @(posedge clk) begin
    if (do_save) begin
      loc_mem[rec_count[IW-1:0]] <= location;
    end
    loc_rd <= loc_mem[look_idx];
  end

  // hold mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      sort_mode <= '0;
    end else if (sort_mode_we) begin
      sort_mode <= sort_mode_wdata;
    end
  end

  // command sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= T_IDLE;
      rec_count     <= '0;
      read_ptr      <= '0;
      sorted_flag   <= 1'b0;
      overflow_flag <= 1'b0;
      done          <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        T_IDLE: begin
          if (accept) begin
            case (cmd_t'(cmd))
              CMD_SAVE: begin
                if (do_save) begin
                  rec_count <= rec_count + CW'(1);
                end else begin
                  overflow_flag <= 1'b1;
                end
              end
              CMD_REWIND: read_ptr <= '0;
              CMD_GET: begin
                if (read_ptr < rec_count) begin
                  state <= sorted_flag ? T_LOOK : T_SORT;
                end else begin
                  done            <= 1'b1;
                  sorted_location <= '0;
                  end_of_list     <= 1'b1;
                  overflow        <= overflow_flag;
                end
              end
              default: ;
            endcase
          end
        end
        T_SORT: begin
          if (sort_done) begin
            sorted_flag <= 1'b1;
            state       <= T_LOOK;
          end
        end
        T_LOOK: state <= T_LOC;
        T_LOC:  state <= T_OUT;
        T_OUT: begin
          done            <= 1'b1;
          sorted_location <= loc_rd;
          end_of_list     <= 1'b0;
          overflow        <= overflow_flag;
          read_ptr        <= read_ptr + CW'(1);
          state           <= T_IDLE;
        end
        default: state <= T_IDLE;
      endcase
    end
  end

  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    read_ptr <= rec_count) else $error("read pointer beyond record count");

  a_word_sorted: assert property (@(posedge clk) disable iff (rst)
    done && !end_of_list |-> sorted_flag) else $error("word returned before sort");

  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    done && end_of_list |-> sorted_location == '0) else $error("end word not zero");

  a_sort_done: assert property (@(posedge clk) disable iff (rst)
    sort_done |-> state == T_SORT) else $error("sort finished outside sort wait");

endmodule
